/* rtl/core/knn_pkg.sv */
// Package: shared types, codes and the default fingerprint library for the matcher.
package knn_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int DEFAULT_COUNT = 60;
    localparam int ADDR_W = 6;
    localparam int RI_W = 16;
    localparam int ABBE_W = 10;
    localparam int ENTRY_W = RI_W + ABBE_W;
    localparam int DIST_W = 35;
    localparam int ROOT_W = 18;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] COUNT_MIN = 7'd3;
    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd64;
    localparam logic [CNT_W-1:0] ENTRIES_RESET = 7'd60;
    localparam logic [9:0] FLOOR_RESET = 10'd150;

    localparam logic [DIST_W-1:0] WEIGHT_N = 35'd3;
    localparam logic [DIST_W-1:0] WEIGHT_V = 35'd10000;
    localparam logic [10:0] CONF_FULL = 11'd1000;
    localparam logic [ROOT_W-1:0] ROOT_LIMIT = 18'd5000;
    // ceil(2^16 / 5); exact floor(r / 5) for r below ROOT_LIMIT
    localparam logic [13:0] RECIP_5 = 14'd13108;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_MATCH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_FLOOR   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_CONF,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } tbl_req_t;

    typedef struct packed {
        logic in_ready;
        logic tbl_we;
        logic tbl_re;
        logic scan_issue;
        logic root_start;
        logic out_load;
    } ctl_t;

    // Result word, first_index (the last field declared) in the lowest bits
    typedef struct packed {
        logic [6:0]         pad;
        logic               index_ok;
        logic [ABBE_W-1:0]  read_abbe;
        logic [RI_W-1:0]    read_refractive;
        logic               identified;
        logic [9:0]         confidence;
        logic [DIST_W-1:0]  third_distance;
        logic [DIST_W-1:0]  second_distance;
        logic [DIST_W-1:0]  first_distance;
        logic [ADDR_W-1:0]  third_index;
        logic [ADDR_W-1:0]  second_index;
        logic [ADDR_W-1:0]  first_index;
    } res_t;

    localparam logic [RI_W-1:0] DEFAULT_RI [TABLE_DEPTH] = '{
        16'd13330, 16'd13611, 16'd13284, 16'd13588, 16'd13776,
        16'd14961, 16'd13750, 16'd14244, 16'd13723, 16'd14735,
        16'd14324, 16'd14318, 16'd14677, 16'd14657, 16'd14778,
        16'd14483, 16'd14667, 16'd14035, 16'd14900, 16'd14580,
        16'd13509, 16'd13686, 16'd13780, 16'd13402, 16'd13635,
        16'd13900, 16'd14490, 16'd13997, 16'd13550, 16'd13505,
        16'd13490, 16'd13448, 16'd13380, 16'd13345, 16'd13460,
        16'd13443, 16'd14080, 16'd13355, 16'd13380, 16'd13450,
        16'd13345, 16'd14770, 16'd14305, 16'd13441, 16'd14070,
        16'd14459, 16'd14601, 16'd15011, 16'd14690, 16'd14780,
        16'd14650, 16'd14660, 16'd14460, 16'd14360, 16'd14030,
        16'd13750, 16'd13820, 16'd13840, 16'd14580, 16'd14600,
        16'd0, 16'd0, 16'd0, 16'd0
    };

    localparam logic [ABBE_W-1:0] DEFAULT_ABBE [TABLE_DEPTH] = '{
        10'd558, 10'd590, 10'd576, 10'd546, 10'd546,
        10'd306, 10'd568, 10'd401, 10'd538, 10'd469,
        10'd479, 10'd496, 10'd472, 10'd471, 10'd454,
        10'd483, 10'd460, 10'd586, 10'd500, 10'd490,
        10'd555, 10'd550, 10'd540, 10'd555, 10'd550,
        10'd545, 10'd490, 10'd530, 10'd550, 10'd552,
        10'd553, 10'd555, 10'd556, 10'd557, 10'd554,
        10'd555, 10'd520, 10'd556, 10'd555, 10'd552,
        10'd557, 10'd470, 10'd492, 10'd560, 10'd518,
        10'd410, 10'd364, 10'd302, 10'd440, 10'd450,
        10'd473, 10'd471, 10'd480, 10'd490, 10'd520,
        10'd540, 10'd530, 10'd525, 10'd495, 10'd490,
        10'd0, 10'd0, 10'd0, 10'd0
    };

endpackage

/* rtl/core/knn_table.sv */
// Fingerprint library memory with per-entry valid bits over the default library.
module knn_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  knn_pkg::tbl_req_t             req,
    output logic [knn_pkg::ENTRY_W-1:0]   rdata
);

    logic [knn_pkg::ENTRY_W-1:0]     mem [knn_pkg::TABLE_DEPTH];
    logic [knn_pkg::TABLE_DEPTH-1:0] vld_reg;
    logic [knn_pkg::ENTRY_W-1:0]     q_reg;
    logic                            q_vld_reg;
    logic [knn_pkg::ADDR_W-1:0]      q_addr_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg      <= mem[req.raddr];
            q_addr_reg <= req.raddr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                q_vld_reg <= vld_reg[req.raddr];
            end
        end
    end

    // Unwritten entries read as the default library
    assign rdata = q_vld_reg ? q_reg
                 : {knn_pkg::DEFAULT_ABBE[q_addr_reg], knn_pkg::DEFAULT_RI[q_addr_reg]};

endmodule

/* rtl/core/knn_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module knn_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [knn_pkg::DIST_W-1:0]   radicand,
    output logic                         done,
    output logic [knn_pkg::ROOT_W-1:0]   root
);

    localparam logic [4:0] LAST_STEP = 5'(knn_pkg::ROOT_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [4:0]                  cnt_reg;
    logic [2*knn_pkg::ROOT_W-1:0] x_reg;
    logic [20:0]                 rem_reg;
    logic [knn_pkg::ROOT_W-1:0]  root_reg;

    logic [20:0] rem_sh;
    logic [20:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[18:0], x_reg[2*knn_pkg::ROOT_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[2*knn_pkg::ROOT_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[knn_pkg::ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/knn_fingerprint_matcher.sv */
// Top level: fingerprint library with write, read and nearest-three match.
// A match reads the N effective entries through a three-stage distance pipeline, drains it,
// then runs 18 square root steps and a confidence step before the result is loaded.
// Throughput: one item at a time, s_tready low meanwhile. Reset: async active low;
// registers return to 60 / 150, the library reads as default.
module knn_fingerprint_matcher
(
    input  logic         clk,
    input  logic         rst_n,
    // Input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // entry_index[5:0], refractive_index[21:6], abbe_number[31:22]
    input  logic [1:0]   s_tuser,   // op[1:0]
    // Result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // first_index, second_index, third_index, first_distance,
                                    // second_distance, third_distance, confidence, identified,
                                    // read_refractive, read_abbe, index_ok, zero pad
    // Configuration writes
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [9:0]   cfg_data
);

    localparam int AW = knn_pkg::ADDR_W;
    localparam int DW = knn_pkg::DIST_W;

    // Sequencer
    knn_pkg::state_t state_reg, state_next;
    knn_pkg::ctl_t   ctl;

    // Configuration
    logic [knn_pkg::CNT_W-1:0] entries_reg;
    logic [9:0]                floor_reg;

    // Latched item
    knn_pkg::op_t               op_reg;
    logic [AW-1:0]              idx_reg;
    logic [knn_pkg::RI_W-1:0]   ri_reg;
    logic [knn_pkg::ABBE_W-1:0] ab_reg;
    logic [knn_pkg::CNT_W-1:0]  count_reg;
    logic [knn_pkg::CNT_W-1:0]  count_next;
    logic [knn_pkg::CNT_W-1:0]  scan_reg;

    // Distance pipeline
    logic          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [AW-1:0] p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [31:0]   sqn_reg;
    logic [19:0]   sqv_reg;
    logic [DW-1:0] dist_reg;

    // Running top three
    logic [AW-1:0] best_idx_reg [3];
    logic [DW-1:0] best_d_reg   [3];
    logic [1:0]    filled_reg;

    logic [9:0]    conf_reg;
    logic          out_valid_reg;
    knn_pkg::res_t out_data_reg;

    logic                        accept;
    logic                        index_ok;
    knn_pkg::tbl_req_t           tbl_req;
    logic [knn_pkg::ENTRY_W-1:0] tbl_rdata;
    logic                        root_done;
    logic [knn_pkg::ROOT_W-1:0]  root;

    logic [knn_pkg::RI_W-1:0]   dn;
    logic [knn_pkg::ABBE_W-1:0] dv;
    logic [knn_pkg::RI_W-1:0]   tbl_ri;
    logic [knn_pkg::ABBE_W-1:0] tbl_ab;
    logic                       pos0, pos1, pos2;
    logic [26:0]                conf_prod;
    logic [9:0]                 conf_next;
    knn_pkg::res_t              res;

    assign accept   = s_tvalid && ctl.in_ready;
    assign s_tready = ctl.in_ready;
    assign index_ok = {1'b0, idx_reg} < count_reg;

    // Clamp the entry count into 3..64 at accept
    always_comb
    begin
        count_next = entries_reg;
        if (entries_reg > knn_pkg::COUNT_MAX)
        begin
            count_next = knn_pkg::COUNT_MAX;
        end
        if (entries_reg < knn_pkg::COUNT_MIN)
        begin
            count_next = knn_pkg::COUNT_MIN;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            knn_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (knn_pkg::op_t'(s_tuser))
                        knn_pkg::OP_WRITE: state_next = knn_pkg::ST_WRITE;
                        knn_pkg::OP_READ:  state_next = knn_pkg::ST_READ;
                        knn_pkg::OP_MATCH: state_next = knn_pkg::ST_SCAN;
                        default:           state_next = knn_pkg::ST_DONE;
                    endcase
                end
            end
            knn_pkg::ST_WRITE: state_next = knn_pkg::ST_DONE;
            knn_pkg::ST_READ:  state_next = knn_pkg::ST_DONE;
            knn_pkg::ST_SCAN:
            begin
                if (scan_reg == count_reg - 7'd1)
                begin
                    state_next = knn_pkg::ST_DRAIN;
                end
            end
            knn_pkg::ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                begin
                    state_next = knn_pkg::ST_ROOT_START;
                end
            end
            knn_pkg::ST_ROOT_START: state_next = knn_pkg::ST_ROOT_WAIT;
            knn_pkg::ST_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    state_next = knn_pkg::ST_CONF;
                end
            end
            knn_pkg::ST_CONF: state_next = knn_pkg::ST_DONE;
            knn_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    state_next = knn_pkg::ST_IDLE;
                end
            end
            default: state_next = knn_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            knn_pkg::ST_IDLE:       ctl.in_ready   = 1'b1;
            knn_pkg::ST_WRITE:      ctl.tbl_we     = index_ok;
            knn_pkg::ST_READ:       ctl.tbl_re     = 1'b1;
            knn_pkg::ST_SCAN:
            begin
                ctl.tbl_re     = 1'b1;
                ctl.scan_issue = 1'b1;
            end
            knn_pkg::ST_ROOT_START: ctl.root_start = 1'b1;
            knn_pkg::ST_DONE:       ctl.out_load   = !out_valid_reg || m_tready;
            default:                ctl = '0;
        endcase
    end

    always_comb
    begin
        tbl_req.we    = ctl.tbl_we;
        tbl_req.waddr = idx_reg;
        tbl_req.wdata = {ab_reg, ri_reg};
        tbl_req.re    = ctl.tbl_re;
        tbl_req.raddr = ctl.scan_issue ? scan_reg[AW-1:0] : idx_reg;
    end

    knn_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    knn_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.root_start),
        .radicand (best_d_reg[0]),
        .done     (root_done),
        .root     (root)
    );

    assign tbl_ri = tbl_rdata[knn_pkg::RI_W-1:0];
    assign tbl_ab = tbl_rdata[knn_pkg::ENTRY_W-1:knn_pkg::RI_W];
    assign dn     = (ri_reg > tbl_ri) ? (ri_reg - tbl_ri) : (tbl_ri - ri_reg);
    assign dv     = (ab_reg > tbl_ab) ? (ab_reg - tbl_ab) : (tbl_ab - ab_reg);

    // Insertion position; a tie keeps the earlier (lower index) entry ahead
    assign pos0 = (filled_reg == 2'd0) || (dist_reg < best_d_reg[0]);
    assign pos1 = (filled_reg < 2'd2)  || (dist_reg < best_d_reg[1]);
    assign pos2 = (filled_reg < 2'd3)  || (dist_reg < best_d_reg[2]);

    // Confidence: 1000 - floor(root / 5), zero once root reaches 5000
    assign conf_prod = root[12:0] * knn_pkg::RECIP_5;
    assign conf_next = (root >= knn_pkg::ROOT_LIMIT) ? 10'd0
                     : 10'(knn_pkg::CONF_FULL - conf_prod[26:16]);

    // Compose the result; fields that mean nothing for the op stay zero
    always_comb
    begin
        res = '0;
        case (op_reg)
            knn_pkg::OP_WRITE: res.index_ok = index_ok;
            knn_pkg::OP_READ:
            begin
                res.index_ok = index_ok;
                if (index_ok)
                begin
                    res.read_refractive = tbl_ri;
                    res.read_abbe       = tbl_ab;
                end
            end
            knn_pkg::OP_MATCH:
            begin
                res.index_ok        = 1'b1;
                res.first_index     = best_idx_reg[0];
                res.second_index    = best_idx_reg[1];
                res.third_index     = best_idx_reg[2];
                res.first_distance  = best_d_reg[0];
                res.second_distance = best_d_reg[1];
                res.third_distance  = best_d_reg[2];
                res.confidence      = conf_reg;
                res.identified      = conf_reg >= floor_reg;
            end
            default: res = '0;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= knn_pkg::op_t'(s_tuser);
            idx_reg   <= s_tdata[5:0];
            ri_reg    <= s_tdata[21:6];
            ab_reg    <= s_tdata[31:22];
            count_reg <= count_next;
        end
        p1_idx_reg <= scan_reg[AW-1:0];
        p2_idx_reg <= p1_idx_reg;
        sqn_reg    <= dn * dn;
        sqv_reg    <= dv * dv;
        p3_idx_reg <= p2_idx_reg;
        dist_reg   <= DW'({3'b0, sqn_reg} * knn_pkg::WEIGHT_N)
                    + DW'({15'b0, sqv_reg} * knn_pkg::WEIGHT_V);
        if (state_reg == knn_pkg::ST_CONF)
        begin
            conf_reg <= conf_next;
        end
        if (ctl.out_load)
        begin
            out_data_reg <= res;
        end
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                best_idx_reg[k] <= '0;
                best_d_reg[k]   <= '0;
            end
        end
        else if (p3_valid_reg)
        begin
            if (pos0)
            begin
                best_idx_reg[2] <= best_idx_reg[1];
                best_d_reg[2]   <= best_d_reg[1];
                best_idx_reg[1] <= best_idx_reg[0];
                best_d_reg[1]   <= best_d_reg[0];
                best_idx_reg[0] <= p3_idx_reg;
                best_d_reg[0]   <= dist_reg;
            end
            else if (pos1)
            begin
                best_idx_reg[2] <= best_idx_reg[1];
                best_d_reg[2]   <= best_d_reg[1];
                best_idx_reg[1] <= p3_idx_reg;
                best_d_reg[1]   <= dist_reg;
            end
            else if (pos2)
            begin
                best_idx_reg[2] <= p3_idx_reg;
                best_d_reg[2]   <= dist_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= knn_pkg::ST_IDLE;
            entries_reg   <= knn_pkg::ENTRIES_RESET;
            floor_reg     <= knn_pkg::FLOOR_RESET;
            scan_reg      <= '0;
            filled_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    knn_pkg::REG_ENTRIES: entries_reg <= cfg_data[knn_pkg::CNT_W-1:0];
                    knn_pkg::REG_FLOOR:   floor_reg   <= cfg_data;
                    default:              floor_reg   <= floor_reg;
                endcase
            end
            // Advance the scan address one entry per cycle
            if (accept)
            begin
                scan_reg <= '0;
            end
            else if (ctl.scan_issue)
            begin
                scan_reg <= scan_reg + 7'd1;
            end
            p1_valid_reg <= ctl.scan_issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (accept)
            begin
                filled_reg <= '0;
            end
            else if (p3_valid_reg && filled_reg != 2'd3)
            begin
                filled_reg <= filled_reg + 2'd1;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/core/knn_checker.sv */
// Port checker for the fingerprint matcher, bound to the top level.
module knn_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no transaction right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // Confidence never exceeds 1000
    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[132:123] <= 10'd1000)
        else $error("confidence out of range");

    // A rejected index or an undefined op carries an all-zero result
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[160] |-> m_tdata[167:0] == 168'd0)
        else $error("nonzero fields with index_ok low");

endmodule

bind knn_fingerprint_matcher knn_checker u_knn_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb.sv */
// Self-checking testbench for the fingerprint matcher: table writes, reads and nearest-three match.
`timescale 1ns / 100ps

module tb;
    import knn_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_200_000;
    localparam int          ITEM_TARGET = 1850;
    localparam int          PHASES = 8;
    // every item answers, so a short settle covers the return to idle
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES = 100;

    // Shadow of the library and registers; predicts one result per accepted
    // item and holds it until the matching result transaction arrives.
    class knn_match_scoreboard;
        logic [RI_W-1:0]   lib_refr [TABLE_DEPTH];
        logic [ABBE_W-1:0] lib_abbe [TABLE_DEPTH];
        logic [CNT_W-1:0]  entries_reg;
        logic [9:0]        floor_reg;
        res_t              expected_q[$];
        int                errors;
        int                n_write, n_read, n_match, n_none, n_ident;

        function new();
            foreach (lib_refr[i])
            begin
                lib_refr[i] = DEFAULT_RI[i];
                lib_abbe[i] = DEFAULT_ABBE[i];
            end
            entries_reg = ENTRIES_RESET;
            floor_reg = FLOOR_RESET;
        endfunction

        function int unsigned active_count();
            int unsigned n;
            n = entries_reg;
            if (n > COUNT_MAX) n = COUNT_MAX;
            if (n < COUNT_MIN) n = COUNT_MIN;
            return n;
        endfunction

        function void set_reg(logic idx, logic [9:0] value);
            if (idx == REG_ENTRIES)
                entries_reg = value[CNT_W-1:0];
            else
                floor_reg = value;
        endfunction

        // Bit-by-bit integer root; 18 bits cover any 35-bit distance.
        function longint unsigned root_of(longint unsigned x);
            longint unsigned r, t;
            r = 0;
            for (int b = ROOT_W - 1; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= x) r = t;
            end
            return r;
        endfunction

        function longint unsigned spread(longint unsigned ri_a, longint unsigned ab_a,
                                         longint unsigned ri_b, longint unsigned ab_b);
            longint unsigned dn, dv;
            dn = ri_a > ri_b ? ri_a - ri_b : ri_b - ri_a;
            dv = ab_a > ab_b ? ab_a - ab_b : ab_b - ab_a;
            return WEIGHT_N * dn * dn + WEIGHT_V * dv * dv;
        endfunction

        function void note_item(op_t op, logic [ADDR_W-1:0] idx,
                                logic [RI_W-1:0] ri, logic [ABBE_W-1:0] ab);
            res_t            r;
            int unsigned     n, filled, pos;
            int unsigned     top_i [3];
            longint unsigned top_d [3];
            longint unsigned d, root5, conf;
            r = '0;
            n = active_count();
            case (op)
                OP_WRITE:
                begin
                    n_write++;
                    if (idx < n)
                    begin
                        lib_refr[idx] = ri;
                        lib_abbe[idx] = ab;
                        r.index_ok = 1'b1;
                    end
                end
                OP_READ:
                begin
                    n_read++;
                    if (idx < n)
                    begin
                        r.read_refractive = lib_refr[idx];
                        r.read_abbe = lib_abbe[idx];
                        r.index_ok = 1'b1;
                    end
                end
                OP_MATCH:
                begin
                    n_match++;
                    filled = 0;
                    top_i = '{0, 0, 0};
                    top_d = '{0, 0, 0};
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        d = spread(ri, ab, lib_refr[i], lib_abbe[i]);
                        // strict compare keeps the lower index ahead on ties
                        pos = 0;
                        while (pos < filled && d >= top_d[pos]) pos++;
                        if (pos < 3)
                        begin
                            for (int k = 2; k > int'(pos); k--)
                            begin
                                top_i[k] = top_i[k-1];
                                top_d[k] = top_d[k-1];
                            end
                            top_i[pos] = i;
                            top_d[pos] = d;
                            if (filled < 3) filled++;
                        end
                    end
                    root5 = root_of(top_d[0]) / 5;
                    conf = root5 >= CONF_FULL ? 0 : CONF_FULL - root5;
                    r.first_index = ADDR_W'(top_i[0]);
                    r.second_index = ADDR_W'(top_i[1]);
                    r.third_index = ADDR_W'(top_i[2]);
                    r.first_distance = DIST_W'(top_d[0]);
                    r.second_distance = DIST_W'(top_d[1]);
                    r.third_distance = DIST_W'(top_d[2]);
                    r.confidence = 10'(conf);
                    r.identified = conf >= floor_reg;
                    r.index_ok = 1'b1;
                    if (r.identified) n_ident++;
                end
                default: n_none++;
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with no pending item");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("first_index", want.first_index, got.first_index);
            compare_field("second_index", want.second_index, got.second_index);
            compare_field("third_index", want.third_index, got.third_index);
            compare_field("first_distance", want.first_distance, got.first_distance);
            compare_field("second_distance", want.second_distance, got.second_distance);
            compare_field("third_distance", want.third_distance, got.third_distance);
            compare_field("confidence", want.confidence, got.confidence);
            compare_field("identified", want.identified, got.identified);
            compare_field("read_refractive", want.read_refractive, got.read_refractive);
            compare_field("read_abbe", want.read_abbe, got.read_abbe);
            compare_field("index_ok", want.index_ok, got.index_ok);
        endfunction
    endclass

    // All block inputs start at known values
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;    // entry_index[5:0], refractive_index[21:6], abbe_number[31:22]
    logic [1:0]   s_tuser = '0;    // op[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;         // result word, first_index lowest, see res_t
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [9:0]   cfg_data = '0;

    knn_match_scoreboard sb = new();
    int unsigned         cycle_count = 0;
    int                  settings_run = 1;

    knn_fingerprint_matcher u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the block stops making progress
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("knn_fingerprint_matcher regression: fail");
            $finish;
        end
    end

    // Result monitor: values read here are the ones present before the edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(res_t'(m_tdata));
    end

    // Receiver backpressure: segments of steady ready, coin flips, hard
    // stalls and toggling, each of random length
    initial
    begin
        int mode, len;
        forever
        begin
            mode = $urandom_range(0, 3);
            len = mode == 2 ? $urandom_range(1, 30) : $urandom_range(10, 200);
            for (int c = 0; c < len; c++)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= 1'b0;
                    default: m_tready <= c[0];
                endcase
            end
        end
    end

    // Present one input transaction and hold it until accepted; valid stays
    // high on return so a burst can chain straight into the next item.
    task automatic send_item(input op_t op, input logic [ADDR_W-1:0] idx,
                             input logic [RI_W-1:0] ri, input logic [ABBE_W-1:0] ab);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {ab, ri, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(op, idx, ri, ab);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [9:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [9:0] entries, input logic [9:0] floor_value);
        drain();
        write_register(REG_ENTRIES, entries);
        write_register(REG_FLOOR, floor_value);
        settings_run++;
    endtask

    // Values cluster around real glass so matches rank closely; a tight
    // cluster makes equal distances, and a tail covers the full field range
    function automatic logic [RI_W-1:0] pick_refr();
        case ($urandom_range(0, 9))
            0: return RI_W'($urandom_range(0, 65535));
            1, 2: return RI_W'(14000 + $urandom_range(0, 2));
            default: return RI_W'($urandom_range(13000, 15200));
        endcase
    endfunction

    function automatic logic [ABBE_W-1:0] pick_abbe();
        case ($urandom_range(0, 9))
            0: return ABBE_W'($urandom_range(0, 1023));
            1, 2: return ABBE_W'(500 + $urandom_range(0, 1));
            default: return ABBE_W'($urandom_range(290, 600));
        endcase
    endfunction

    task automatic random_item(output op_t op, output logic [ADDR_W-1:0] idx,
                               output logic [RI_W-1:0] ri, output logic [ABBE_W-1:0] ab);
        int pick, j, t;
        pick = $urandom_range(0, 99);
        op = pick < 30 ? OP_WRITE : pick < 60 ? OP_READ : pick < 96 ? OP_MATCH : OP_NONE;
        // mostly addressable indices, the rest anywhere in the 6-bit span
        idx = $urandom_range(0, 4) == 0 ? ADDR_W'($urandom_range(0, 63))
                                        : ADDR_W'($urandom_range(0, sb.active_count() - 1));
        ri = pick_refr();
        ab = pick_abbe();
        // measurement near a stored entry: high confidence, floor decides
        if (op == OP_MATCH && $urandom_range(0, 9) < 4)
        begin
            j = $urandom_range(0, sb.active_count() - 1);
            t = int'(sb.lib_refr[j]) + int'($urandom_range(0, 40)) - 20;
            ri = t < 0 ? RI_W'(0) : t > 65535 ? RI_W'(65535) : RI_W'(t);
            t = int'(sb.lib_abbe[j]) + int'($urandom_range(0, 6)) - 3;
            ab = t < 0 ? ABBE_W'(0) : t > 1023 ? ABBE_W'(1023) : ABBE_W'(t);
        end
    endtask

    // Bursts of random length separated by random gaps, sometimes none
    task automatic run_items(input int target);
        op_t                op;
        logic [ADDR_W-1:0]  idx;
        logic [RI_W-1:0]    ri;
        logic [ABBE_W-1:0]  ab;
        int                 done, burst;
        done = 0;
        while (done < target)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && done < target; b++)
            begin
                random_item(op, idx, ri, ab);
                send_item(op, idx, ri, ab);
                // no-op items leave the block untouched; do not count them
                if (op != OP_NONE) done++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [9:0] entries, floor_value;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset library and default registers (60 entries, floor 150)
        send_item(OP_READ, 6'd0, '0, '0);
        send_item(OP_READ, 6'd59, '0, '0);
        send_item(OP_READ, 6'd60, '0, '0);               // past the count
        send_item(OP_WRITE, 6'd63, 16'hFFFF, 10'h3FF);   // past the count, ignored
        send_item(OP_NONE, 6'h3F, 16'hFFFF, 10'h3FF);
        send_item(OP_MATCH, '0, 16'd14961, 10'd306);     // exact hit, full confidence
        send_item(OP_MATCH, '0, 16'd0, 10'd0);
        send_item(OP_MATCH, '0, 16'hFFFF, 10'h3FF);      // largest distances, zero confidence
        send_item(OP_WRITE, 6'd0, 16'hFFFF, 10'h3FF);
        send_item(OP_READ, 6'd0, '0, '0);
        send_item(OP_WRITE, 6'd1, 16'd14000, 10'd500);
        send_item(OP_WRITE, 6'd2, 16'd14000, 10'd500);
        send_item(OP_MATCH, '0, 16'd14000, 10'd500);     // tie, lower index first
        send_item(OP_WRITE, 6'd59, 16'd0, 10'd0);
        send_item(OP_MATCH, '0, 16'd1, 10'd1);

        // Full table, highest legal floor
        apply_settings(10'd64, 10'd1000);
        send_item(OP_READ, 6'd63, '0, '0);
        send_item(OP_WRITE, 6'd63, 16'd14000, 10'd500);
        send_item(OP_MATCH, '0, 16'd14000, 10'd500);     // three-way tie, exactly at floor
        send_item(OP_MATCH, '0, 16'd14000, 10'd501);     // just under the floor

        // Count below minimum raises to three; zero floor
        apply_settings(10'd0, 10'd0);
        send_item(OP_READ, 6'd3, '0, '0);
        send_item(OP_WRITE, 6'd3, 16'd1, 10'd1);
        send_item(OP_MATCH, '0, 16'd0, 10'd0);

        // Count above the table saturates; floor beyond range never identifies
        apply_settings(10'd127, 10'd1023);
        send_item(OP_MATCH, '0, 16'd14000, 10'd500);
        send_item(OP_READ, 6'd63, '0, '0);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin entries = 10'd60;  floor_value = 10'd150;  end
                1: begin entries = 10'd3;   floor_value = 10'd0;    end
                2: begin entries = 10'd64;  floor_value = 10'd1000; end
                3: begin entries = 10'd127; floor_value = 10'd1023; end
                4: begin entries = 10'd0;   floor_value = 10'($urandom_range(0, 1023)); end
                default:
                begin
                    entries = 10'($urandom_range(3, 64));
                    floor_value = 10'($urandom_range(0, 1000));
                end
            endcase
            apply_settings(entries, floor_value);
            run_items(ITEM_TARGET / PHASES);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d writes, %0d reads, %0d matches (%0d identified), %0d no-ops",
                 sb.n_write, sb.n_read, sb.n_match, sb.n_ident, sb.n_none);
        $display("across %0d register settings in %0d cycles, %0d mismatches",
                 settings_run, cycle_count, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("knn_fingerprint_matcher regression: pass");
        else
            $display("knn_fingerprint_matcher regression: fail");
        $finish;
    end

endmodule
